[design/tbcp_pkg.sv]
// Shared types and constants for the text box cell placer.
// Used by the front part, the back part and the top level; depends on nothing else.
`default_nettype none

package tbcp_pkg;

  localparam int unsigned CoordBitsDef = 13;
  localparam int unsigned QueueDepth   = 2;

  localparam int unsigned CharBits    = 21;
  localparam int unsigned AttrBits    = 16;
  localparam int unsigned OriginBits  = 12;
  localparam int unsigned BoxBits     = 13;
  localparam int unsigned ModeBits    = 2;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CharBits-1:0] CodeLf    = 21'd10;
  localparam logic [CharBits-1:0] CodeCr    = 21'd13;
  localparam logic [CharBits-1:0] CodeSpace = 21'd32;
  localparam logic [CharBits-1:0] CodeTab   = 21'd9;

  localparam logic [ModeBits-1:0] ModeWrap   = 2'd0;
  localparam logic [ModeBits-1:0] ModeTrunc  = 2'd2;
  localparam logic [ModeBits-1:0] ModeRepeat = 2'd3;

  localparam logic [CfgIdxBits-1:0] RegOriginCol = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegOriginRow = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegBoxCols   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegBoxRows   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegMode      = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegForeAttr  = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegBackAttr  = 3'd6;

  localparam logic [BoxBits-1:0] BoxColsRst = 13'd80;
  localparam logic [BoxBits-1:0] BoxRowsRst = 13'd24;

  typedef struct packed {
    logic [OriginBits-1:0] origin_col;
    logic [OriginBits-1:0] origin_row;
    logic [BoxBits-1:0]    box_cols;
    logic [BoxBits-1:0]    box_rows;
    logic [ModeBits-1:0]   layout_mode;
    logic [AttrBits-1:0]   fore_attr;
    logic [AttrBits-1:0]   back_attr;
  } cfg_t;

  // Character after classification by the front part
  typedef struct packed {
    logic [CharBits-1:0] codepoint;
    logic                first;
    logic                last;
    logic                is_lf;
    logic                is_cr;
    logic                is_blank;
  } cls_item_t;

endpackage

`default_nettype wire

[design/tbcp_fifo.sv]
// Small register queue with registered storage, used between the parts of the block.
// Depends on nothing else.
`default_nettype none

module tbcp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             pop_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[design/tbcp_front.sv]
// Front part: accepts characters, classifies them and queues them for the back part.
// Depends on tbcp_pkg and tbcp_fifo.
`default_nettype none

module tbcp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [tbcp_pkg::CharBits-1:0] codepoint_i,
  input  logic                        first_of_call_i,
  input  logic                        end_of_text_i,
  input  logic                        take_i,
  output tbcp_pkg::cls_item_t         item_o,
  output logic                        valid_o
);
  import tbcp_pkg::*;

  cls_item_t in_item;
  logic      q_empty;

  always_comb begin
    in_item.codepoint = codepoint_i;
    in_item.first     = first_of_call_i;
    in_item.last      = end_of_text_i;
    in_item.is_lf     = (codepoint_i == CodeLf);
    in_item.is_cr     = (codepoint_i == CodeCr);
    in_item.is_blank  = (codepoint_i == CodeSpace) || (codepoint_i == CodeTab);
  end

  tbcp_fifo #(
    .Width ($bits(cls_item_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (take_i),
    .wdata_i (in_item),
    .rdata_o (item_o),
    .full_o  (full),
    .empty_o (q_empty)
  );

  assign valid_o = !q_empty;

endmodule

`default_nettype wire

[design/tbcp_back.sv]
// Back part: cursor and flag state, places one classified character per cycle
// while take_i is high. Depends on tbcp_pkg.
`default_nettype none

module tbcp_back #(
  parameter int unsigned CoordBits = tbcp_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbcp_pkg::cfg_t                cfg_i,
  input  tbcp_pkg::cls_item_t           item_i,
  input  logic                          take_i,
  output logic                          write_enable_o,
  output logic [CoordBits-1:0]          cell_col_o,
  output logic [CoordBits-1:0]          cell_row_o,
  output logic [tbcp_pkg::CharBits-1:0] cell_char_o,
  output logic [tbcp_pkg::AttrBits-1:0] cell_fore_o,
  output logic [tbcp_pkg::AttrBits-1:0] cell_back_o,
  output logic                          finished_o,
  output logic                          replay_request_o
);
  import tbcp_pkg::*;

  // Compare width: holds cursor + 1 and origin + box size without overflow
  localparam int unsigned LimW = (CoordBits + 1 > BoxBits + 1) ? CoordBits + 1 : BoxBits + 1;

  logic [CoordBits-1:0] cursor_col_q, cursor_col_d, cursor_row_q, cursor_row_d;
  logic                 cr_pending_q, cr_pending_d;
  logic                 just_wrapped_q, just_wrapped_d;
  logic                 stopped_q, stopped_d;

  logic [LimW-1:0]      origin_col_w, origin_row_w, col_lim_p1, row_lim_p1;
  logic [CoordBits-1:0] origin_col_c, origin_row_c, col_b, row_b;
  logic                 cr_b, jw_b, stop_b, at_right, at_bottom, hold_blank, nl, we;

  assign origin_col_w = LimW'(cfg_i.origin_col);
  assign origin_row_w = LimW'(cfg_i.origin_row);
  assign origin_col_c = origin_col_w[CoordBits-1:0];
  assign origin_row_c = origin_row_w[CoordBits-1:0];
  assign col_lim_p1   = origin_col_w + LimW'(cfg_i.box_cols);
  assign row_lim_p1   = origin_row_w + LimW'(cfg_i.box_rows);

  always_comb begin
    // a new print restarts at the origin with clean flags
    col_b  = item_i.first ? origin_col_c : cursor_col_q;
    row_b  = item_i.first ? origin_row_c : cursor_row_q;
    cr_b   = item_i.first ? 1'b0 : cr_pending_q;
    jw_b   = item_i.first ? 1'b0 : just_wrapped_q;
    stop_b = item_i.first ? 1'b0 : stopped_q;

    // cursor >= limit - 1, rewritten as cursor + 1 >= limit
    at_right   = (LimW'(col_b) + 1'b1) >= col_lim_p1;
    at_bottom  = (LimW'(row_b) + 1'b1) >= row_lim_p1;
    hold_blank = jw_b && (cfg_i.layout_mode == ModeWrap) && item_i.is_blank &&
                 (col_b == origin_col_c);

    cursor_col_d   = col_b;
    cursor_row_d   = row_b;
    cr_pending_d   = cr_b;
    just_wrapped_d = jw_b;
    stopped_d      = stop_b;
    we             = 1'b0;
    nl             = 1'b0;

    if (!stop_b) begin
      if (item_i.is_lf && cr_b) begin
        cr_pending_d = 1'b0;
      end else if (item_i.is_lf || item_i.is_cr) begin
        nl = 1'b1;
      end else begin
        cr_pending_d = 1'b0;
        we           = 1'b1;
        if (at_right) begin
          nl             = 1'b1;
          just_wrapped_d = 1'b1;
        end else if (!hold_blank) begin
          cursor_col_d   = col_b + 1'b1;
          just_wrapped_d = 1'b0;
        end
      end

      if (nl) begin
        if ((cfg_i.layout_mode == ModeTrunc) || at_bottom) begin
          stopped_d = 1'b1;
        end else begin
          cr_pending_d = item_i.is_cr;
          cursor_row_d = row_b + 1'b1;
          cursor_col_d = origin_col_c;
        end
      end
    end
  end

  assign write_enable_o   = we;
  assign cell_col_o       = we ? col_b : '0;
  assign cell_row_o       = we ? row_b : '0;
  assign cell_char_o      = we ? item_i.codepoint : '0;
  assign cell_fore_o      = we ? cfg_i.fore_attr : '0;
  assign cell_back_o      = we ? cfg_i.back_attr : '0;
  assign finished_o       = stopped_d;
  assign replay_request_o = item_i.last && (cfg_i.layout_mode == ModeRepeat) && !stopped_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q   <= '0;
      cursor_row_q   <= '0;
      cr_pending_q   <= 1'b0;
      just_wrapped_q <= 1'b0;
      stopped_q      <= 1'b0;
    end else if (take_i) begin
      cursor_col_q   <= cursor_col_d;
      cursor_row_q   <= cursor_row_d;
      cr_pending_q   <= cr_pending_d;
      just_wrapped_q <= just_wrapped_d;
      stopped_q      <= stopped_d;
    end
  end

endmodule

`default_nettype wire

[design/text_box_cell_placer.sv]
// Text box cell placer: top level with configuration registers and result queue.
// Path: front queue, back part placement, result queue; a full result queue stalls it.
// Throughput: one character per cycle if the result queue has room; set by the cursor update.
// Two-entry queues sit between front and back and before the result ports.
// Reset: registers to defaults (80 x 24 box at 0,0, wrap mode), cursor and flags zero,
// queues empty.
`default_nettype none

module text_box_cell_placer #(
  parameter int unsigned CoordBits = tbcp_pkg::CoordBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tbcp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [tbcp_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [tbcp_pkg::CharBits-1:0]    codepoint_i,
  input  logic                             first_of_call_i,
  input  logic                             end_of_text_i,
  output logic                             empty,
  input  logic                             pop,
  output logic                             write_enable_o,
  output logic [CoordBits-1:0]             cell_col_o,
  output logic [CoordBits-1:0]             cell_row_o,
  output logic [tbcp_pkg::CharBits-1:0]    cell_char_o,
  output logic [tbcp_pkg::AttrBits-1:0]    cell_fore_o,
  output logic [tbcp_pkg::AttrBits-1:0]    cell_back_o,
  output logic                             finished_o,
  output logic                             replay_request_o
);
  import tbcp_pkg::*;

  localparam int unsigned ResW = 2 * CoordBits + CharBits + 2 * AttrBits + 3;

  cfg_t      cfg_q;
  cls_item_t item;
  logic      item_valid, back_take, out_full;
  logic      b_we, b_fin, b_rep;
  logic [CoordBits-1:0] b_col, b_row;
  logic [CharBits-1:0]  b_char;
  logic [AttrBits-1:0]  b_fore, b_back;
  logic [ResW-1:0]      res_wdata, res_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_col  <= '0;
      cfg_q.origin_row  <= '0;
      cfg_q.box_cols    <= BoxColsRst;
      cfg_q.box_rows    <= BoxRowsRst;
      cfg_q.layout_mode <= ModeWrap;
      cfg_q.fore_attr   <= '0;
      cfg_q.back_attr   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegOriginCol: cfg_q.origin_col  <= cfg_data_i[OriginBits-1:0];
        RegOriginRow: cfg_q.origin_row  <= cfg_data_i[OriginBits-1:0];
        RegBoxCols:   cfg_q.box_cols    <= cfg_data_i[BoxBits-1:0];
        RegBoxRows:   cfg_q.box_rows    <= cfg_data_i[BoxBits-1:0];
        RegMode:      cfg_q.layout_mode <= cfg_data_i[ModeBits-1:0];
        RegForeAttr:  cfg_q.fore_attr   <= cfg_data_i[AttrBits-1:0];
        RegBackAttr:  cfg_q.back_attr   <= cfg_data_i[AttrBits-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  tbcp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .codepoint_i     (codepoint_i),
    .first_of_call_i (first_of_call_i),
    .end_of_text_i   (end_of_text_i),
    .take_i          (back_take),
    .item_o          (item),
    .valid_o         (item_valid)
  );

  // advance the back part when a character is queued and the result queue has room
  assign back_take = item_valid && !out_full;

  tbcp_back #(
    .CoordBits (CoordBits)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .item_i           (item),
    .take_i           (back_take),
    .write_enable_o   (b_we),
    .cell_col_o       (b_col),
    .cell_row_o       (b_row),
    .cell_char_o      (b_char),
    .cell_fore_o      (b_fore),
    .cell_back_o      (b_back),
    .finished_o       (b_fin),
    .replay_request_o (b_rep)
  );

  assign res_wdata = {b_we, b_col, b_row, b_char, b_fore, b_back, b_fin, b_rep};

  tbcp_fifo #(
    .Width (ResW),
    .Depth (QueueDepth)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_take),
    .pop_i   (pop),
    .wdata_i (res_wdata),
    .rdata_o (res_rdata),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign {write_enable_o, cell_col_o, cell_row_o, cell_char_o, cell_fore_o, cell_back_o,
          finished_o, replay_request_o} = res_rdata;

  assert property (@(posedge clk_i) disable iff (!rst_ni) back_take |=> !empty)
    else $error("result missing after back part transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && replay_request_o) |-> !finished_o)
    else $error("replay requested on a finished print");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !write_enable_o) |-> (cell_char_o == '0 && cell_col_o == '0 &&
                                     cell_row_o == '0))
    else $error("cell fields not cleared on a result without write");

endmodule

`default_nettype wire
